// ===== rtl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg: shared definitions for the sorted-array priority queue
// Operation and status codes, default sizes and the per-cycle command
// that the top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package sapq_pkg;

  // Default sizes.
  localparam int DEPTH_DEF      = 64;
  localparam int TAG_WIDTH_DEF  = 16;
  localparam int PRIO_WIDTH_DEF = 16;

  // Field widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell at once.
  typedef struct packed {
    logic insert;  // place the new item in order
    logic remove;  // shift every entry one place toward the head
  } cell_cmd_t;

endpackage

// ===== rtl/sapq_cell.sv =====
// ----------------------------------------------------------------------------
// sapq_cell: one storage cell of the sorted chain
// Holds one entry and, on each command, keeps it, takes the new item,
// takes the left neighbor's entry (insert) or the right one's (remove).
// ----------------------------------------------------------------------------
module sapq_cell #(
  parameter int TAG_WIDTH  = sapq_pkg::TAG_WIDTH_DEF,
  parameter int PRIO_WIDTH = sapq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                          clk,
  input  sapq_pkg::cell_cmd_t           cmd,
  input  logic                          occupied,    // this cell holds an entry
  input  logic [TAG_WIDTH-1:0]          new_tag,
  input  logic signed [PRIO_WIDTH-1:0]  new_prio,
  input  logic                          left_ahead,  // left neighbor stays ahead
  input  logic [TAG_WIDTH-1:0]          left_tag,
  input  logic signed [PRIO_WIDTH-1:0]  left_prio,
  input  logic [TAG_WIDTH-1:0]          right_tag,
  input  logic signed [PRIO_WIDTH-1:0]  right_prio,
  output logic                          ahead,       // entry stays ahead of new item
  output logic [TAG_WIDTH-1:0]          tag,
  output logic signed [PRIO_WIDTH-1:0]  prio
);

  logic [TAG_WIDTH-1:0]         tag_r;
  logic signed [PRIO_WIDTH-1:0] prio_r;
  logic [TAG_WIDTH-1:0]         tag_nxt;
  logic signed [PRIO_WIDTH-1:0] prio_nxt;

  // Equal priorities stay ahead, so ties leave in arrival order.
  assign ahead = occupied && (prio_r <= new_prio);

  // Next entry of this cell.
  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    priority if (cmd.insert) begin
      if (!ahead) begin
        if (left_ahead) begin
          tag_nxt  = new_tag;
          prio_nxt = new_prio;
        end else begin
          tag_nxt  = left_tag;
          prio_nxt = left_prio;
        end
      end
    end else if (cmd.remove) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign tag  = tag_r;
  assign prio = prio_r;

endmodule

// ===== rtl/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue: priority queue built as a chain of cells
// Keeps up to DEPTH tagged entries sorted by signed priority and answers
// insert, remove-smallest and clear with one status result each.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream: op, item_tag and item_priority are
//   packed in in_tdata. Each accepted request yields exactly one result on
//   the out_ stream with the status, the removed tag, the new head entry
//   and the occupancy after the operation.
//   Every cell compares its own priority with the new item in parallel and
//   shifts together, so one request is taken per clock unless the receiver
//   stalls the output. A result appears in the cycle after its request
//   transfer, from the output register. The input stays ready while that
//   register is empty or being drained; when the receiver stalls, the held
//   result waits and no further request is taken until out_tready returns.
//   Reset empties the queue (occupancy zero) and drops any held result; no
//   clearing pass is needed, since only occupied cells are ever read.
//   A full queue reports an insert as dropped, an empty one a remove as
//   failed; in both cases the queue is left unchanged. Op code 3 is a
//   no-op that reports the current head.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
  parameter int DEPTH      = sapq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH  = sapq_pkg::TAG_WIDTH_DEF,
  parameter int PRIO_WIDTH = sapq_pkg::PRIO_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_BITS   = sapq_pkg::OP_W + TAG_WIDTH + PRIO_WIDTH,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = sapq_pkg::STATUS_W + 1 + 2 * TAG_WIDTH + PRIO_WIDTH + CNT_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // Fields from bit 0 up: op, item_tag, item_priority.
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // Fields from bit 0 up: status, removed_tag, head_valid, head_tag,
  // head_priority, occupancy.
  output logic [OUT_W-1:0] out_tdata
);

  localparam int TAG_LO  = sapq_pkg::OP_W;
  localparam int PRIO_LO = sapq_pkg::OP_W + TAG_WIDTH;

  logic in_xfer;
  logic [sapq_pkg::OP_W-1:0]    op;
  logic [TAG_WIDTH-1:0]         item_tag;
  logic signed [PRIO_WIDTH-1:0] item_prio;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             empty;

  sapq_pkg::cell_cmd_t cmd;
  logic [sapq_pkg::STATUS_W-1:0] status;
  logic [TAG_WIDTH-1:0]          removed_tag;
  logic                          head_valid;
  logic [TAG_WIDTH-1:0]          head_tag;
  logic signed [PRIO_WIDTH-1:0]  head_prio;
  logic [TAG_WIDTH-1:0]          head_tag_nxt;
  logic signed [PRIO_WIDTH-1:0]  head_prio_nxt;

  logic                         occ    [DEPTH];
  logic                         ahead  [DEPTH];
  logic [TAG_WIDTH-1:0]         c_tag  [DEPTH];
  logic signed [PRIO_WIDTH-1:0] c_prio [DEPTH];

  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  // Input unpacking and handshake.
  assign op        = in_tdata[sapq_pkg::OP_W-1:0];
  assign item_tag  = in_tdata[TAG_LO +: TAG_WIDTH];
  assign item_prio = in_tdata[PRIO_LO +: PRIO_WIDTH];
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Command decode and new occupancy.
  always_comb begin
    cmd         = '0;
    status      = sapq_pkg::ST_OK;
    count_nxt   = count_r;
    removed_tag = '0;
    if (in_xfer) begin
      unique case (op)
        sapq_pkg::OP_INSERT: begin
          if (full) begin
            status = sapq_pkg::ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        sapq_pkg::OP_REMOVE: begin
          if (empty) begin
            status = sapq_pkg::ST_EMPTY;
          end else begin
            cmd.remove  = 1'b1;
            count_nxt   = count_r - CNT_W'(1);
            removed_tag = c_tag[0];
          end
        end
        sapq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Occupancy register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Chain of cells; each sees its neighbors' entries.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      if (DEPTH > 1) begin : g_more
        sapq_cell #(.TAG_WIDTH(TAG_WIDTH), .PRIO_WIDTH(PRIO_WIDTH)) u_cell (
          .clk(clk), .cmd(cmd), .occupied(occ[i]),
          .new_tag(item_tag), .new_prio(item_prio),
          .left_ahead(1'b1), .left_tag(item_tag), .left_prio(item_prio),
          .right_tag(c_tag[i+1]), .right_prio(c_prio[i+1]),
          .ahead(ahead[i]), .tag(c_tag[i]), .prio(c_prio[i])
        );
      end else begin : g_one
        sapq_cell #(.TAG_WIDTH(TAG_WIDTH), .PRIO_WIDTH(PRIO_WIDTH)) u_cell (
          .clk(clk), .cmd(cmd), .occupied(occ[i]),
          .new_tag(item_tag), .new_prio(item_prio),
          .left_ahead(1'b1), .left_tag(item_tag), .left_prio(item_prio),
          .right_tag(c_tag[i]), .right_prio(c_prio[i]),
          .ahead(ahead[i]), .tag(c_tag[i]), .prio(c_prio[i])
        );
      end
    end else if (i == DEPTH - 1) begin : g_last
      sapq_cell #(.TAG_WIDTH(TAG_WIDTH), .PRIO_WIDTH(PRIO_WIDTH)) u_cell (
        .clk(clk), .cmd(cmd), .occupied(occ[i]),
        .new_tag(item_tag), .new_prio(item_prio),
        .left_ahead(ahead[i-1]), .left_tag(c_tag[i-1]), .left_prio(c_prio[i-1]),
        .right_tag(c_tag[i]), .right_prio(c_prio[i]),
        .ahead(ahead[i]), .tag(c_tag[i]), .prio(c_prio[i])
      );
    end else begin : g_mid
      sapq_cell #(.TAG_WIDTH(TAG_WIDTH), .PRIO_WIDTH(PRIO_WIDTH)) u_cell (
        .clk(clk), .cmd(cmd), .occupied(occ[i]),
        .new_tag(item_tag), .new_prio(item_prio),
        .left_ahead(ahead[i-1]), .left_tag(c_tag[i-1]), .left_prio(c_prio[i-1]),
        .right_tag(c_tag[i+1]), .right_prio(c_prio[i+1]),
        .ahead(ahead[i]), .tag(c_tag[i]), .prio(c_prio[i])
      );
    end
  end

  // Head entry after this operation, mirrored from the first cell's update.
  if (DEPTH > 1) begin : g_head_next
    always_comb begin
      head_tag_nxt  = c_tag[0];
      head_prio_nxt = c_prio[0];
      priority if (cmd.insert && !ahead[0]) begin
        head_tag_nxt  = item_tag;
        head_prio_nxt = item_prio;
      end else if (cmd.remove) begin
        head_tag_nxt  = c_tag[1];
        head_prio_nxt = c_prio[1];
      end
    end
  end else begin : g_head_one
    always_comb begin
      head_tag_nxt  = c_tag[0];
      head_prio_nxt = c_prio[0];
      if (cmd.insert) begin
        head_tag_nxt  = item_tag;
        head_prio_nxt = item_prio;
      end
    end
  end

  assign head_valid = (count_nxt != '0);
  assign head_tag   = head_valid ? head_tag_nxt : '0;
  assign head_prio  = head_valid ? head_prio_nxt : '0;

  // Output register: loads on each request transfer, holds while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_xfer) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_tdata_r <= OUT_W'({count_nxt, head_prio, head_tag, head_valid,
                             removed_tag, status});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== tb/sv/tb_sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue: self-checking bench for the priority queue
// Sends a short directed sequence and then phases of insert-heavy,
// balanced and remove-heavy traffic with random tags and priorities. Both
// stream sides see random gaps. A scoreboard keeps its own sorted copy of
// the queue and checks every result field by field, in order.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue;

  // Sizes and packing of the stream words.
  localparam int DEPTH    = sapq_pkg::DEPTH_DEF;
  localparam int TAG_W    = sapq_pkg::TAG_WIDTH_DEF;
  localparam int PRIO_W   = sapq_pkg::PRIO_WIDTH_DEF;
  localparam int OP_W     = sapq_pkg::OP_W;
  localparam int STATUS_W = sapq_pkg::STATUS_W;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IN_BITS  = OP_W + TAG_W + PRIO_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + 1 + 2 * TAG_W + PRIO_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int RM_LSB = STATUS_W;
  localparam int HV_BIT = RM_LSB + TAG_W;
  localparam int HT_LSB = HV_BIT + 1;
  localparam int HP_LSB = HT_LSB + TAG_W;
  localparam int OC_LSB = HP_LSB + PRIO_W;

  // Number of requests in one run.
  localparam int NUM_ITEMS = 1550;

  // The spare op code is a no-op.
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [TAG_W-1:0]         removed_tag;
    logic                     head_valid;
    logic [TAG_W-1:0]         head_tag;
    logic signed [PRIO_W-1:0] head_prio;
    logic [CNT_W-1:0]         occupancy;
  } result_t;

  typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} load_mix_t;
  typedef enum {PRIO_WIDE, PRIO_CLUSTER, PRIO_EDGE} prio_profile_t;

  // Sorted shadow copy of the queue and the results it predicts.
  class queue_scoreboard;
    logic [TAG_W-1:0]         tag_mem [DEPTH];
    logic signed [PRIO_W-1:0] prio_mem [DEPTH];
    int                       entry_count;
    result_t                  expected_results[$];
    int                       errors;

    function new();
      entry_count = 0;
      errors      = 0;
    endfunction

    // Apply one accepted request to the shadow queue and queue its result.
    function void note_request(request_t req);
      result_t res;
      int pos;
      res.status      = sapq_pkg::ST_OK;
      res.removed_tag = '0;
      if (req.op == sapq_pkg::OP_INSERT) begin
        if (entry_count >= DEPTH) begin
          res.status = sapq_pkg::ST_FULL;
        end else begin
          // Equal priorities stay in arrival order.
          pos = 0;
          while (pos < entry_count && prio_mem[pos] <= req.prio) pos++;
          for (int j = entry_count; j > pos; j--) begin
            tag_mem[j]  = tag_mem[j-1];
            prio_mem[j] = prio_mem[j-1];
          end
          tag_mem[pos]  = req.tag;
          prio_mem[pos] = req.prio;
          entry_count++;
        end
      end else if (req.op == sapq_pkg::OP_REMOVE) begin
        if (entry_count == 0) begin
          res.status = sapq_pkg::ST_EMPTY;
        end else begin
          res.removed_tag = tag_mem[0];
          for (int j = 1; j < entry_count; j++) begin
            tag_mem[j-1]  = tag_mem[j];
            prio_mem[j-1] = prio_mem[j];
          end
          entry_count--;
        end
      end else if (req.op == sapq_pkg::OP_CLEAR) begin
        entry_count = 0;
      end
      res.head_valid = (entry_count > 0);
      res.head_tag   = res.head_valid ? tag_mem[0] : '0;
      res.head_prio  = res.head_valid ? prio_mem[0] : '0;
      res.occupancy  = CNT_W'(entry_count);
      expected_results.push_back(res);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.removed_tag !== exp.removed_tag) begin
        $error("removed_tag: expected %0h, got %0h", exp.removed_tag, got.removed_tag);
        errors++;
      end
      if (got.head_valid !== exp.head_valid) begin
        $error("head_valid: expected %0d, got %0d", exp.head_valid, got.head_valid);
        errors++;
      end
      if (got.head_tag !== exp.head_tag) begin
        $error("head_tag: expected %0h, got %0h", exp.head_tag, got.head_tag);
        errors++;
      end
      if (got.head_prio !== exp.head_prio) begin
        $error("head_priority: expected %0d, got %0d", exp.head_prio, got.head_prio);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  queue_scoreboard board = new();
  int              idle_pct = 30;

  sorted_array_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(load_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 88) return sapq_pkg::OP_INSERT;
        if (roll < 98) return sapq_pkg::OP_REMOVE;
        return OP_NOP;
      end
      MIX_DRAIN: begin
        if (roll < 15) return sapq_pkg::OP_INSERT;
        if (roll < 95) return sapq_pkg::OP_REMOVE;
        if (roll < 97) return sapq_pkg::OP_CLEAR;
        return OP_NOP;
      end
      default: begin
        if (roll < 46) return sapq_pkg::OP_INSERT;
        if (roll < 92) return sapq_pkg::OP_REMOVE;
        if (roll < 95) return sapq_pkg::OP_CLEAR;
        return OP_NOP;
      end
    endcase
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_prio(prio_profile_t profile);
    logic signed [PRIO_W-1:0] corners [7];
    corners = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFE, 16'sh7FFF};
    case (profile)
      PRIO_CLUSTER: return PRIO_W'($signed($urandom_range(0, 6)) - 3);
      PRIO_EDGE:    return corners[$urandom_range(0, 6)];
      default:      return PRIO_W'($urandom);
    endcase
  endfunction

  // Drive one request and return at the edge where it transfers.
  task automatic send_request(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                              logic signed [PRIO_W-1:0] prio);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-IN_BITS){1'b0}}, prio, tag, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Watch both channels; inputs first so a same-edge result finds its prediction.
  always @(posedge clk) begin
    request_t req;
    result_t  res;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        req.op   = in_tdata[OP_W-1:0];
        req.tag  = in_tdata[OP_W +: TAG_W];
        req.prio = in_tdata[OP_W+TAG_W +: PRIO_W];
        board.note_request(req);
      end
      if (out_tvalid && out_tready) begin
        res.status      = out_tdata[STATUS_W-1:0];
        res.removed_tag = out_tdata[RM_LSB +: TAG_W];
        res.head_valid  = out_tdata[HV_BIT];
        res.head_tag    = out_tdata[HT_LSB +: TAG_W];
        res.head_prio   = out_tdata[HP_LSB +: PRIO_W];
        res.occupancy   = out_tdata[OC_LSB +: CNT_W];
        board.check_result(res);
      end
    end
  end

  // Result side: alternate ready runs with random stalls.
  initial begin : result_sink
    int hold;
    out_tready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Directed sequence, then phases of random traffic.
  initial begin : stimulus
    int        sent;
    int        phase;
    int        phase_len;
    load_mix_t mix;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-queue cases: remove fails, no-op and clear report nothing held.
    send_request(sapq_pkg::OP_REMOVE, 16'h0000, 16'sd0);
    send_request(OP_NOP, 16'hFFFF, -16'sd1);
    send_request(sapq_pkg::OP_CLEAR, 16'h0000, 16'sd0);
    // Priority extremes and a tie that must leave in arrival order.
    send_request(sapq_pkg::OP_INSERT, 16'h0000, 16'sd0);
    send_request(sapq_pkg::OP_INSERT, 16'hFFFF, 16'sh7FFF);
    send_request(sapq_pkg::OP_INSERT, 16'h1234, 16'sh8000);
    send_request(sapq_pkg::OP_INSERT, 16'hAAAA, 16'sd0);
    send_request(sapq_pkg::OP_INSERT, 16'h5555, -16'sd1);
    send_request(OP_NOP, 16'h0000, 16'sd0);
    repeat (5) send_request(sapq_pkg::OP_REMOVE, 16'hFFFF, 16'sh7FFF);
    send_request(sapq_pkg::OP_REMOVE, 16'h0000, 16'sd0);
    // Clear with entries held.
    send_request(sapq_pkg::OP_INSERT, 16'h0F0F, 16'sh7FFF);
    send_request(sapq_pkg::OP_INSERT, 16'hF0F0, 16'sh8000);
    send_request(sapq_pkg::OP_CLEAR, 16'hFFFF, -16'sd1);
    send_request(sapq_pkg::OP_REMOVE, 16'h0000, 16'sd0);
    send_request(sapq_pkg::OP_INSERT, 16'h0001, 16'sd1);
    sent = 20;

    // Fill phases reach the full queue, drain phases the empty one.
    phase = 0;
    while (sent < NUM_ITEMS) begin
      case (phase % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      phase_len = (mix == MIX_FILL) ? $urandom_range(140, 160) : $urandom_range(90, 130);
      if (phase_len > NUM_ITEMS - sent) phase_len = NUM_ITEMS - sent;
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 70;
        default: idle_pct = 30;
      endcase
      repeat (phase_len) begin
        send_request(pick_op(mix), TAG_W'($urandom_range(0, 65535)),
                     pick_prio(prio_profile_t'($urandom_range(0, 2))));
        sent++;
      end
      phase++;
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
